// ----- sv/ssp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared codes and widths of the symmetric sparse permutation block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int OPCODE_W = 3;
  localparam int SLOT_W   = 14;
  localparam int INDEX_W  = 10;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET_PERM = 3'd0,
    OP_LOAD     = 3'd1,
    OP_COMPUTE  = 3'd2,
    OP_READ_PTR = 3'd3,
    OP_READ_ENT = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ----- sv/symmetric_sparse_permute.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// symmetric_sparse_permute
// Symmetric permutation of a lower-triangular sparse matrix in column form.
//
// A command is transferred when start is high and busy is low. Every command
// gives exactly one result, shown for one cycle with done high; the receiver
// cannot stall it. The dimension register is written over its own cfg
// channel, whose ready is high while the block is idle and no command is
// being started.
// A permutation write ends in the idle state that takes it; a kept load
// passes through S_LOAD_RD and S_LOAD_WR, and a read in range through
// S_READ, after a synchronous memory read. Compute first sweeps every
// column, one per cycle, to build the pointers, then scatters kept entries
// through S_SC_RD, S_SC_POS and S_SC_WR, because each scattered entry does
// a read-modify-write of its column's fill position; a last S_SC_RD ends it.
// After reset the block sweeps every entry of the count memory to zero,
// with busy high; configuration writes wait until the sweep has ended.
// Entries never written in the permutation, pointer or output memories read
// as arbitrary values.
// ----------------------------------------------------------------------------
module symmetric_sparse_permute #(
  parameter int MAX_DIM = 1024,
  parameter int MAX_NNZ = 8192
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire [ssp_pkg::OPCODE_W-1:0]        opcode,
  input  wire [ssp_pkg::SLOT_W-1:0]          slot,
  input  wire [ssp_pkg::INDEX_W-1:0]         new_index,
  input  wire [ssp_pkg::INDEX_W-1:0]         entry_column,
  input  wire [ssp_pkg::INDEX_W-1:0]         entry_row,
  input  wire signed [ssp_pkg::VALUE_W-1:0]  entry_value,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [ssp_pkg::DIM_W-1:0]           cfg_data,
  output logic                               done,
  output logic [ssp_pkg::STATUS_W-1:0]       status,
  output logic [ssp_pkg::SLOT_W-1:0]         pointer_value,
  output logic [ssp_pkg::INDEX_W-1:0]        permuted_row,
  output logic signed [ssp_pkg::VALUE_W-1:0] permuted_value
);
  import ssp_pkg::*;

  localparam int DA = $clog2(MAX_DIM);
  localparam int NA = $clog2(MAX_NNZ);
  localparam int DC = $clog2(MAX_DIM + 1);
  localparam int NC = $clog2(MAX_NNZ + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_PFX, S_SC_RD, S_SC_POS, S_SC_WR,
    S_READ
  } state_t;

  // memories
  logic [INDEX_W-1:0] perm_mem [MAX_DIM];
  logic [NC-1:0]      cnt_mem  [MAX_DIM];
  logic [NC-1:0]      fill_mem [MAX_DIM];
  logic [NC-1:0]      ptr_mem  [MAX_DIM+1];
  logic [INDEX_W-1:0] krow_mem [MAX_NNZ];
  logic [INDEX_W-1:0] kcol_mem [MAX_NNZ];
  logic [VALUE_W-1:0] kval_mem [MAX_NNZ];
  logic [INDEX_W-1:0] orow_mem [MAX_NNZ];
  logic [VALUE_W-1:0] oval_mem [MAX_NNZ];

  state_t             state;
  logic [DIM_W-1:0]   dimension;
  logic [NC-1:0]      kept_total;
  logic [DC-1:0]      col;
  logic [NC-1:0]      acc;
  logic [NC-1:0]      k;
  logic [INDEX_W-1:0] lo, hi;
  logic [VALUE_W-1:0] val_q;
  logic               rd_ptr;
  logic [INDEX_W-1:0] pc_rd, pr_rd, kc_rd, kr_rd, or_rd;
  logic [VALUE_W-1:0] kv_rd, ov_rd;
  logic [NC-1:0]      cnt_rd, fill_rd, ptr_rd;

  logic [DIM_W-1:0]   dim;
  logic               accept;
  logic [DA-1:0]      cnt_addr;
  logic [INDEX_W-1:0] lo_n, hi_n;

  always_comb begin
    dim = dimension;
    if (dimension == '0) dim = DIM_W'(1);
    else if (32'(dimension) > MAX_DIM) dim = DIM_W'(MAX_DIM);
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign lo_n      = (pr_rd < pc_rd) ? pr_rd : pc_rd;
  assign hi_n      = (pr_rd < pc_rd) ? pc_rd : pr_rd;

  always_comb begin
    cnt_addr = col[DA-1:0];
    if (state == S_LOAD_RD) cnt_addr = DA'(lo_n);
  end

  // synchronous reads
  always_ff @(posedge clk) begin
    if (accept) begin
      pc_rd <= perm_mem[entry_column[DA-1:0]];
      pr_rd <= perm_mem[entry_row[DA-1:0]];
      ptr_rd <= ptr_mem[slot[DC-1:0]];
      or_rd <= orow_mem[slot[NA-1:0]];
      ov_rd <= oval_mem[slot[NA-1:0]];
    end
    cnt_rd <= cnt_mem[cnt_addr];
    kc_rd  <= kcol_mem[k[NA-1:0]];
    kr_rd  <= krow_mem[k[NA-1:0]];
    kv_rd  <= kval_mem[k[NA-1:0]];
    fill_rd <= fill_mem[DA'(kc_rd)];
  end

  // writes
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_SET_PERM && 32'(slot) < 32'(dim)
        && 32'(new_index) < 32'(dim)) begin
      perm_mem[slot[DA-1:0]] <= new_index;
    end
    if (state == S_CLEAR) cnt_mem[col[DA-1:0]] <= '0;
    if (state == S_LOAD_WR) begin
      cnt_mem[DA'(lo)] <= cnt_rd + NC'(1);
      krow_mem[kept_total[NA-1:0]] <= hi;
      kcol_mem[kept_total[NA-1:0]] <= lo;
      kval_mem[kept_total[NA-1:0]] <= val_q;
    end
    if (state == S_PFX && rd_ptr) begin
      ptr_mem[col - DC'(1)] <= acc;
      if (32'(col) <= MAX_DIM) fill_mem[DA'(col - DC'(1))] <= acc;
    end
    if (state == S_SC_WR) begin
      fill_mem[DA'(kc_rd)] <= fill_rd + NC'(1);
      if (32'(fill_rd) < MAX_NNZ) begin
        orow_mem[fill_rd[NA-1:0]] <= kr_rd;
        oval_mem[fill_rd[NA-1:0]] <= kv_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; dimension <= DIM_W'(1); kept_total <= '0;
      col <= '0; k <= '0; done <= 1'b0; rd_ptr <= 1'b0; acc <= '0;
      status <= ST_OK; pointer_value <= '0; permuted_row <= '0;
      permuted_value <= '0; lo <= '0; hi <= '0; val_q <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) dimension <= cfg_data;
      case (state)
        S_CLEAR: begin
          col <= col + DC'(1);
          if (32'(col) == MAX_DIM - 1) begin
            state <= S_IDLE; col <= '0;
          end
        end
        S_IDLE: begin
          if (start) begin
            status <= ST_OK; pointer_value <= '0; permuted_row <= '0;
            permuted_value <= '0; val_q <= entry_value;
            case (opcode)
              OP_SET_PERM: begin
                done <= 1'b1;
                if (32'(slot) >= 32'(dim) || 32'(new_index) >= 32'(dim))
                  status <= ST_RANGE;
              end
              OP_LOAD: begin
                if (32'(entry_column) >= 32'(dim) || 32'(entry_row) >= 32'(dim))
                begin
                  status <= ST_RANGE; done <= 1'b1;
                end else if (entry_row < entry_column) begin
                  done <= 1'b1;
                end else begin
                  state <= S_LOAD_RD;
                end
              end
              OP_COMPUTE: begin
                state <= S_PFX; col <= '0; acc <= '0; rd_ptr <= 1'b0;
              end
              OP_READ_PTR: begin
                if (32'(slot) > 32'(dim)) begin
                  status <= ST_RANGE; done <= 1'b1;
                end else begin
                  state <= S_READ; rd_ptr <= 1'b1;
                end
              end
              OP_READ_ENT: begin
                if (32'(slot) >= 32'(kept_total)) begin
                  status <= ST_RANGE; done <= 1'b1;
                end else begin
                  state <= S_READ; rd_ptr <= 1'b0;
                end
              end
              default: begin
                status <= ST_RANGE; done <= 1'b1;
              end
            endcase
          end
        end
        S_LOAD_RD: begin
          lo <= lo_n; hi <= hi_n;
          if (32'(pc_rd) >= 32'(dim) || 32'(pr_rd) >= 32'(dim)) begin
            status <= ST_RANGE; done <= 1'b1; state <= S_IDLE;
          end else if (32'(kept_total) >= MAX_NNZ) begin
            status <= ST_FULL; done <= 1'b1; state <= S_IDLE;
          end else begin
            state <= S_LOAD_WR;
          end
        end
        S_LOAD_WR: begin
          kept_total <= kept_total + NC'(1);
          done <= 1'b1; state <= S_IDLE;
        end
        S_PFX: begin
          // count of column col-1 arrives in the cycle after its address
          if (rd_ptr) acc <= acc + cnt_rd;
          rd_ptr <= 1'b1;
          col <= col + DC'(1);
          if (32'(col) == MAX_DIM + 1) begin
            state <= S_SC_RD; k <= '0; col <= '0;
          end
        end
        S_SC_RD: begin
          if (k >= kept_total) begin
            done <= 1'b1; state <= S_IDLE;
          end else begin
            state <= S_SC_POS;
          end
        end
        S_SC_POS: state <= S_SC_WR;
        S_SC_WR: begin
          k <= k + NC'(1); state <= S_SC_RD;
        end
        S_READ: begin
          done <= 1'b1; state <= S_IDLE;
          if (rd_ptr) pointer_value <= SLOT_W'(ptr_rd);
          else begin
            permuted_row <= or_rd; permuted_value <= ov_rd;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result outside idle");
  a_total_grow: assert property (@(posedge clk) disable iff (rst)
    kept_total != $past(kept_total) |-> $past(state) == S_LOAD_WR)
    else $error("kept total changed outside a load");
  a_cap: assert property (@(posedge clk) disable iff (rst)
    32'(kept_total) <= MAX_NNZ) else $error("kept total past capacity");

endmodule
`default_nettype wire
